@@ design/blg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the battery level gauge.
// Holds the charge curve tables; used by every module of the block.
package blg_pkg;

    localparam int VOLT_W     = 13;
    localparam int LEVEL_W    = 13;
    localparam int LEVEL_FULL = 4096;
    localparam int SEG_N      = 12;
    localparam int SEG_W      = 4;
    localparam int NUM_W      = 12;
    localparam int DELTA_W    = 8;
    localparam int RECIP_W    = 28;
    localparam int RECIP_SHIFT = 36;
    localparam int FRAC_SHIFT = 12;
    localparam int STEP2_FIRST_SEG = 4;

    localparam int WINDOW_DEF      = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Curve breakpoints in millivolts.
    localparam logic [VOLT_W-1:0] BRK_MV [0:SEG_N] = '{
        13'd3400, 13'd3500, 13'd3680, 13'd3700, 13'd3730, 13'd3770, 13'd3790,
        13'd3820, 13'd3870, 13'd3930, 13'd4000, 13'd4080, 13'd4100
    };

    // Segment start level in 5% units times segment span.
    localparam logic [10:0] SEG_BASE_NUM [0:SEG_N-1] = '{
        11'd0, 11'd180, 11'd40, 11'd90, 11'd160, 11'd120,
        11'd240, 11'd500, 11'd720, 11'd980, 11'd1280, 11'd360
    };

    // ceil(2^36 / (20 * span)) per segment; exact for numerators below 2^24.
    localparam logic [RECIP_W-1:0] SEG_RECIP [0:SEG_N-1] = '{
        28'(((64'd1 << 36) + 64'd2000 - 64'd1) / 64'd2000),
        28'(((64'd1 << 36) + 64'd3600 - 64'd1) / 64'd3600),
        28'(((64'd1 << 36) + 64'd400  - 64'd1) / 64'd400),
        28'(((64'd1 << 36) + 64'd600  - 64'd1) / 64'd600),
        28'(((64'd1 << 36) + 64'd800  - 64'd1) / 64'd800),
        28'(((64'd1 << 36) + 64'd400  - 64'd1) / 64'd400),
        28'(((64'd1 << 36) + 64'd600  - 64'd1) / 64'd600),
        28'(((64'd1 << 36) + 64'd1000 - 64'd1) / 64'd1000),
        28'(((64'd1 << 36) + 64'd1200 - 64'd1) / 64'd1200),
        28'(((64'd1 << 36) + 64'd1400 - 64'd1) / 64'd1400),
        28'(((64'd1 << 36) + 64'd1600 - 64'd1) / 64'd1600),
        28'(((64'd1 << 36) + 64'd400  - 64'd1) / 64'd400)
    };

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
    } t_raw_beat;

endpackage
`default_nettype wire

@@ design/blg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts voltage samples and maps them onto the charge curve.
// Two pipeline stages; depends on blg_pkg.
module blg_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [blg_pkg::VOLT_W-1:0] i_voltage_mv,
    output blg_pkg::t_raw_beat              o_beat,
    input  wire logic                       i_beat_ready
);
    import blg_pkg::*;

    logic               r_v1, r_v2;
    logic               r_below, r_full;
    logic [SEG_W-1:0]   r_seg;
    logic [NUM_W-1:0]   r_num;
    logic [LEVEL_W-1:0] r_level;

    logic               en1, en2;
    logic [SEG_W-1:0]   seg;
    logic [VOLT_W-1:0]  delta_full;
    logic [DELTA_W-1:0] delta;
    logic [NUM_W-1:0]   num;
    logic [NUM_W+FRAC_SHIFT-1:0]         scaled;
    logic [NUM_W+FRAC_SHIFT+RECIP_W-1:0] prod;
    logic [LEVEL_W-1:0] level;

    assign en2        = !r_v2 || i_beat_ready;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    // Pick the highest segment whose start lies at or below the sample.
    always_comb begin
        seg = '0;
        for (int k = 1; k < SEG_N; k++) begin
            if (i_voltage_mv >= BRK_MV[k]) begin
                seg = SEG_W'(k);
            end
        end
        delta_full = i_voltage_mv - BRK_MV[seg];
        delta      = delta_full[DELTA_W-1:0];
        if (seg >= SEG_W'(STEP2_FIRST_SEG)) begin
            num = NUM_W'(SEG_BASE_NUM[seg]) + NUM_W'({delta, 1'b0});
        end else begin
            num = NUM_W'(SEG_BASE_NUM[seg]) + NUM_W'(delta);
        end
    end

    // Divide by 20 * span through the segment reciprocal.
    always_comb begin
        scaled = {r_num, FRAC_SHIFT'(0)};
        prod   = (NUM_W+FRAC_SHIFT+RECIP_W)'(scaled) *
                 (NUM_W+FRAC_SHIFT+RECIP_W)'(SEG_RECIP[r_seg]);
        if (r_below) begin
            level = '0;
        end else if (r_full) begin
            level = LEVEL_W'(LEVEL_FULL);
        end else begin
            level = prod[RECIP_SHIFT +: LEVEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
        if (en1 && i_in_valid) begin
            r_below <= (i_voltage_mv < BRK_MV[0]);
            r_full  <= (i_voltage_mv >= BRK_MV[SEG_N]);
            r_seg   <= seg;
            r_num   <= num;
        end
        if (en2 && r_v1) begin
            r_level <= level;
        end
    end

    assign o_beat.valid = r_v2;
    assign o_beat.level = r_level;

endmodule
`default_nettype wire

@@ design/blg_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Short queue of raw levels between the curve front end and the filter.
// Depends on blg_pkg.
module blg_queue #(
    parameter int DEPTH = blg_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire blg_pkg::t_raw_beat i_beat,
    output logic               o_beat_ready,
    output blg_pkg::t_raw_beat o_beat,
    input  wire logic          i_beat_ready
);
    import blg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [LEVEL_W-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push, pop;

    assign o_beat_ready = (r_count != CNT_W'(DEPTH));
    assign push         = i_beat.valid && o_beat_ready;
    assign o_beat.valid = (r_count != '0);
    assign o_beat.level = r_mem[r_rd_ptr];
    assign pop          = o_beat.valid && i_beat_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_beat.level;
        end
    end

endmodule
`default_nettype wire

@@ design/blg_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Back end: moving-average filter over the level history and output register.
// Depends on blg_pkg.
module blg_back #(
    parameter int WINDOW = blg_pkg::WINDOW_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire blg_pkg::t_raw_beat          i_beat,
    output logic                             o_beat_ready,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [blg_pkg::LEVEL_W-1:0]      o_filtered_level,
    output logic [blg_pkg::LEVEL_W-1:0]      o_raw_level
);
    import blg_pkg::*;

    localparam int SUM_W   = $clog2(WINDOW * LEVEL_FULL + 1);
    localparam int RECIP_K = SUM_W + $clog2(WINDOW);
    localparam logic [RECIP_K-1:0] RecipMul =
        RECIP_K'(((64'd1 << RECIP_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int HIST_N  = WINDOW - 1;

    logic [LEVEL_W-1:0] r_hist [0:HIST_N-1];
    logic [SUM_W-1:0]   r_sum;
    logic               r_primed;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_filt, r_raw;

    logic                     take;
    logic [SUM_W-1:0]         total;
    logic [SUM_W+RECIP_K-1:0] prod;
    logic [LEVEL_W-1:0]       avg;
    logic [SUM_W-1:0]         n_sum;

    assign o_beat_ready = !r_out_valid || i_out_ready;
    assign take         = i_beat.valid && o_beat_ready;

    // r_sum holds history entries 0..WINDOW-2, the ones that stay in the window.
    always_comb begin
        total = r_sum + SUM_W'(i_beat.level);
        prod  = (SUM_W+RECIP_K)'(total) * (SUM_W+RECIP_K)'(RecipMul);
        if (r_primed) begin
            avg   = prod[RECIP_K +: LEVEL_W];
            n_sum = r_sum + SUM_W'(avg) - SUM_W'(r_hist[HIST_N-1]);
        end else begin
            avg   = i_beat.level;
            n_sum = SUM_W'(i_beat.level * (WINDOW - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_primed    <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_sum     <= n_sum;
            r_hist[0] <= avg;
            for (int i = 1; i < HIST_N; i++) begin
                r_hist[i] <= r_primed ? r_hist[i-1] : i_beat.level;
            end
            r_filt <= avg;
            r_raw  <= i_beat.level;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_level = r_filt;
    assign o_raw_level      = r_raw;

endmodule
`default_nettype wire

@@ design/battery_level_gauge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Battery level gauge top level: curve front end, raw level queue, filter back end.
// Depends on blg_pkg, blg_front, blg_queue and blg_back.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_voltage_mv
//  out      output     o_out_valid / i_out_ready  o_filtered_level, o_raw_level
//
// One transaction per cycle sustained while i_out_ready stays high; the filter's
// running-sum loop in blg_back (add, reciprocal multiply, update) sets that figure.
// From input transaction to the earliest output transaction a sample passes
// two curve stages, one queue slot and one output register.
// Reset is synchronous, active low; it clears valids, queue pointers and the
// primed flag. The history is not cleared: the first sample loads it.
// Output stalls fill the queue first, then the two curve stages; the input side
// stalls only once all of them are full.
module battery_level_gauge #(
    parameter int WINDOW      = blg_pkg::WINDOW_DEF,
    parameter int QUEUE_DEPTH = blg_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [blg_pkg::VOLT_W-1:0]  i_voltage_mv,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [blg_pkg::LEVEL_W-1:0]      o_filtered_level,
    output logic [blg_pkg::LEVEL_W-1:0]      o_raw_level
);
    import blg_pkg::*;

    t_raw_beat front_beat, queue_beat;
    logic      queue_ready, back_ready;

    // Classify the sample into a curve segment and compute its raw level.
    blg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_voltage_mv (i_voltage_mv),
        .o_beat       (front_beat),
        .i_beat_ready (queue_ready)
    );

    // Hold raw levels so the front end keeps going while the output stalls.
    blg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (front_beat),
        .o_beat_ready (queue_ready),
        .o_beat       (queue_beat),
        .i_beat_ready (back_ready)
    );

    // Advance the moving average and present the result.
    blg_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_beat           (queue_beat),
        .o_beat_ready     (back_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_level (o_filtered_level),
        .o_raw_level      (o_raw_level)
    );

endmodule
`default_nettype wire
